// ----- hdl/c3f_pkg.sv -----
// Shared types, register codes and kernel tables for the 3x3 image filter.
// Depends on nothing; used by conv3x3_image_filter.
package c3f_pkg;

    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_CHANNELS = 4;

    typedef logic [15:0]        sample_t;
    typedef logic signed [20:0] coef_t;

    typedef enum logic [1:0] {
        CFG_FILTER_MODE,
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_CHANNEL_COUNT
    } cfg_index_t;

    typedef enum logic [2:0] {
        MODE_LOWPASS,
        MODE_LAPLACIAN,
        MODE_HGRAD,
        MODE_VGRAD,
        MODE_HIGHPASS,
        MODE_BOXCAR,
        MODE_IDENTITY
    } filter_mode_t;

    // Q16 coefficients, row-major over the 3x3 kernel
    localparam coef_t LOWPASS_K [9] = '{21'sd4681, 21'sd7802, 21'sd4681,
        21'sd7802, 21'sd15604, 21'sd7802, 21'sd4681, 21'sd7802, 21'sd4681};
    localparam coef_t LAPLACE_K [9] = '{-21'sd4096, -21'sd4096, -21'sd4096,
        -21'sd4096, 21'sd32768, -21'sd4096, -21'sd4096, -21'sd4096, -21'sd4096};
    localparam coef_t HGRAD_K [9] = '{21'sd10923, 21'sd0, -21'sd10923,
        21'sd10923, 21'sd0, -21'sd10923, 21'sd10923, 21'sd0, -21'sd10923};
    localparam coef_t VGRAD_K [9] = '{21'sd10923, 21'sd10923, 21'sd10923,
        21'sd0, 21'sd0, 21'sd0, -21'sd10923, -21'sd10923, -21'sd10923};
    localparam coef_t HIPASS_K [9] = '{-21'sd65536, -21'sd131072, -21'sd65536,
        -21'sd131072, 21'sd851968, -21'sd131072, -21'sd65536, -21'sd131072,
        -21'sd65536};
    localparam coef_t BOX_K [9] = '{21'sd7282, 21'sd7282, 21'sd7282,
        21'sd7282, 21'sd7282, 21'sd7282, 21'sd7282, 21'sd7282, 21'sd7282};
    localparam coef_t IDENT_K [9] = '{21'sd0, 21'sd0, 21'sd0,
        21'sd0, 21'sd65536, 21'sd0, 21'sd0, 21'sd0, 21'sd0};

    // Kernel tap k of a mode; the undefined mode acts as identity
    function automatic coef_t kern_coef(logic [2:0] mode, logic [3:0] k);
        coef_t c;
        case (mode)
            MODE_LOWPASS:   c = LOWPASS_K[k];
            MODE_LAPLACIAN: c = LAPLACE_K[k];
            MODE_HGRAD:     c = HGRAD_K[k];
            MODE_VGRAD:     c = VGRAD_K[k];
            MODE_HIGHPASS:  c = HIPASS_K[k];
            MODE_BOXCAR:    c = BOX_K[k];
            default:        c = IDENT_K[k];
        endcase
        return c;
    endfunction

    // Output offset: one half for the signed-gradient style kernels
    function automatic logic [20:0] mode_offset(logic [2:0] mode);
        logic [20:0] o;
        case (mode)
            MODE_LAPLACIAN, MODE_HGRAD, MODE_VGRAD: o = 21'd32768;
            default:                                o = 21'd0;
        endcase
        return o;
    endfunction

endpackage

// ----- hdl/conv3x3_image_filter.sv -----
// 3x3 convolution filter with clamp-to-edge borders over a raster sample stream.
// Holds the line store memory, window registers and the multiply/add pipeline.
// Depends on c3f_pkg.
//
// Accepts one sample per clock unless the output stalls or an earlier sample still
// has results to leave. A sample normally yields at most one result; the sample
// that closes a row or the last row yields up to four, which leave one per clock
// while the input is held and the output is not stalled. The rate is set by the
// line store (one read and one write per sample) and the one shared multiply
// stage. The line store needs no clearing: entries are always written in the
// current frame before their use.
module conv3x3_image_filter #(
    parameter int MAX_WIDTH    = c3f_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = c3f_pkg::DEF_MAX_CHANNELS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [20:0] filtered, [36:21] out_row,
                                   // [47:37] out_col, [49:48] out_chan, zero fill
    output logic        m_tlast    // frame_last
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW    = CW + CHW;
    localparam int DEPTH = MAX_WIDTH << CHW;

    // ---------------- configuration registers ----------------
    logic [2:0]  mode_reg;
    logic [11:0] width_reg;
    logic [15:0] height_reg;
    logic [2:0]  chans_reg;
    logic        geom_wr;

    assign geom_wr = cfg_wr_en && (cfg_addr != c3f_pkg::CFG_FILTER_MODE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= c3f_pkg::MODE_IDENTITY;
            width_reg  <= 12'd1;
            height_reg <= 16'd1;
            chans_reg  <= 3'd1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                c3f_pkg::CFG_FILTER_MODE:   mode_reg   <= cfg_wr_data[2:0];
                c3f_pkg::CFG_IMAGE_WIDTH:   width_reg  <= cfg_wr_data[11:0];
                c3f_pkg::CFG_IMAGE_HEIGHT:  height_reg <= cfg_wr_data;
                c3f_pkg::CFG_CHANNEL_COUNT: chans_reg  <= cfg_wr_data[2:0];
                default: ;
            endcase
        end
    end

    // Effective geometry: zero acts as one, oversize clamps to the maximum
    logic [15:0] eff_w, eff_h;
    logic [2:0]  eff_nc;
    assign eff_w  = (width_reg == 12'd0) ? 16'd1 :
                    ({4'd0, width_reg} > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH) :
                    {4'd0, width_reg};
    assign eff_h  = (height_reg == 16'd0) ? 16'd1 : height_reg;
    assign eff_nc = (chans_reg == 3'd0) ? 3'd1 :
                    (chans_reg > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : chans_reg;

    // ---------------- position counters ----------------
    logic [15:0]   row_reg;
    logic [CW-1:0] col_reg;
    logic [1:0]    chan_reg;
    logic          last_row, last_col, last_ch, acc, en;

    assign last_row = (row_reg == eff_h - 16'd1);
    assign last_col = (16'(col_reg) == eff_w - 16'd1);
    assign last_ch  = ({1'b0, chan_reg} == eff_nc - 3'd1);
    assign acc      = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn || geom_wr) begin
            row_reg  <= '0;
            col_reg  <= '0;
            chan_reg <= '0;
        end else if (acc) begin
            if (last_ch) begin
                chan_reg <= '0;
                if (last_col) begin
                    col_reg <= '0;
                    row_reg <= last_row ? 16'd0 : row_reg + 16'd1;
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end else begin
                chan_reg <= chan_reg + 2'd1;
            end
        end
    end

    // ---------------- stage 1: line store read, window update ----------------
    logic          s1_v_reg, s1_leave, s2_free;
    c3f_pkg::sample_t s1_x_reg;
    logic [AW-1:0] s1_addr_reg, rd_addr;
    logic [1:0]    s1_ch_reg;
    logic [15:0]   s1_row_reg, s1_col_reg;
    logic          s1_rlast_reg, s1_clast_reg, s1_chlast_reg;

    assign rd_addr  = {col_reg, chan_reg[CHW-1:0]};
    assign en       = !m_tvalid || m_tready;
    assign s1_leave = s1_v_reg && en && s2_free;
    assign s_tready = !s1_v_reg || s1_leave;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (acc) begin
            s1_v_reg <= 1'b1;
        end else if (s1_leave) begin
            s1_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_x_reg      <= s_tdata;
            s1_addr_reg   <= rd_addr;
            s1_ch_reg     <= chan_reg;
            s1_row_reg    <= row_reg;
            s1_col_reg    <= 16'(col_reg);
            s1_rlast_reg  <= last_row;
            s1_clast_reg  <= last_col;
            s1_chlast_reg <= last_ch;
        end
    end

    // Line store: upper half is row R-2, lower half row R-1
    logic [31:0] line_mem [0:DEPTH-1];
    logic [31:0] rd_q_reg;
    logic        fwd_v_reg;
    logic [31:0] fwd_data_reg;
    c3f_pkg::sample_t p1, p2;

    assign p1 = fwd_v_reg ? fwd_data_reg[15:0]  : rd_q_reg[15:0];
    assign p2 = fwd_v_reg ? fwd_data_reg[31:16] : rd_q_reg[31:16];

    always_ff @(posedge aclk) begin
        if (acc) begin
            rd_q_reg <= line_mem[rd_addr];
        end
        if (s1_leave) begin
            line_mem[s1_addr_reg] <= {p1, s1_x_reg};
        end
    end

    // Forward the write that lands on the same edge as the read of that entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_v_reg <= 1'b0;
        end else if (acc || s1_leave) begin
            fwd_v_reg <= acc && s1_leave && (s1_addr_reg == rd_addr);
        end
    end

    // Hold the written entry until the next write
    always_ff @(posedge aclk) begin
        if (s1_leave) begin
            fwd_data_reg <= {p1, s1_x_reg};
        end
    end

    // Window columns C-1 and C per channel; newest column comes from the store and the input sample
    c3f_pkg::sample_t win_a_reg [MAX_CHANNELS][3];
    c3f_pkg::sample_t win_b_reg [MAX_CHANNELS][3];
    c3f_pkg::sample_t col_new [3];
    logic [CHW-1:0]   wch;

    assign wch        = s1_ch_reg[CHW-1:0];
    assign col_new[0] = p2;
    assign col_new[1] = p1;
    assign col_new[2] = s1_x_reg;

    always_ff @(posedge aclk) begin
        if (s1_leave) begin
            for (int k = 0; k < 3; k++) begin
                win_a_reg[wch][k] <= win_b_reg[wch][k];
                win_b_reg[wch][k] <= col_new[k];
            end
        end
    end

    // Result set: bit0 (r-1,c-1), bit1 (r-1,c), bit2 (r,c-1), bit3 (r,c)
    logic [3:0] s1_mask;
    logic       r_ge1, c_ge1;
    assign r_ge1   = (s1_row_reg != 16'd0);
    assign c_ge1   = (s1_col_reg != 16'd0);
    assign s1_mask = {s1_rlast_reg && s1_clast_reg, s1_rlast_reg && c_ge1,
                      r_ge1 && s1_clast_reg, r_ge1 && c_ge1};

    // ---------------- stage 2: expand into single results ----------------
    logic             s2_v_reg, s2_last, s2_chlast_reg;
    logic [3:0]       s2_mask_reg, s2_pick;
    c3f_pkg::sample_t s2_win_reg [3][3];
    logic [1:0]       s2_rsa_reg [3], s2_rsb_reg [3], s2_csa_reg [3], s2_csb_reg [3];
    logic [15:0]      s2_row_reg, s2_col_reg;
    logic [1:0]       s2_ch_reg;

    assign s2_pick = s2_mask_reg & (~s2_mask_reg + 4'd1);
    assign s2_last = ((s2_mask_reg & (s2_mask_reg - 4'd1)) == 4'd0);
    assign s2_free = !s2_v_reg || (en && s2_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
        end else if (s1_leave) begin
            s2_v_reg <= (s1_mask != 4'd0);
        end else if (en && s2_v_reg && s2_last) begin
            s2_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_leave) begin
            s2_mask_reg   <= s1_mask;
            s2_row_reg    <= s1_row_reg;
            s2_col_reg    <= s1_col_reg;
            s2_ch_reg     <= s1_ch_reg;
            s2_chlast_reg <= s1_chlast_reg;
            for (int k = 0; k < 3; k++) begin
                s2_win_reg[0][k] <= win_a_reg[wch][k];
                s2_win_reg[1][k] <= win_b_reg[wch][k];
                s2_win_reg[2][k] <= col_new[k];
            end
            // Clamped window slots for the previous and current row/column
            s2_rsa_reg[0] <= (s1_row_reg == 16'd1) ? 2'd1 : 2'd0;
            s2_rsa_reg[1] <= 2'd1;
            s2_rsa_reg[2] <= 2'd2;
            s2_rsb_reg[0] <= r_ge1 ? 2'd1 : 2'd2;
            s2_rsb_reg[1] <= 2'd2;
            s2_rsb_reg[2] <= 2'd2;
            s2_csa_reg[0] <= (s1_col_reg == 16'd1) ? 2'd1 : 2'd0;
            s2_csa_reg[1] <= 2'd1;
            s2_csa_reg[2] <= 2'd2;
            s2_csb_reg[0] <= c_ge1 ? 2'd1 : 2'd2;
            s2_csb_reg[1] <= 2'd2;
            s2_csb_reg[2] <= 2'd2;
        end else if (en && s2_v_reg) begin
            s2_mask_reg <= s2_mask_reg & ~s2_pick;
        end
    end

    // Select the taps of the picked result
    logic             k_row, k_col;
    logic [1:0]       rs [3], cs [3];
    c3f_pkg::sample_t tap [9];
    logic [15:0]      res_row, res_col;
    logic             res_last;

    assign k_row = s2_pick[2] || s2_pick[3];
    assign k_col = s2_pick[1] || s2_pick[3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rs[k] = k_row ? s2_rsb_reg[k] : s2_rsa_reg[k];
            cs[k] = k_col ? s2_csb_reg[k] : s2_csa_reg[k];
        end
        for (int ky = 0; ky < 3; ky++) begin
            for (int kx = 0; kx < 3; kx++) begin
                tap[ky*3+kx] = s2_win_reg[cs[kx]][rs[ky]];
            end
        end
    end

    assign res_row  = k_row ? s2_row_reg : s2_row_reg - 16'd1;
    assign res_col  = k_col ? s2_col_reg : s2_col_reg - 16'd1;
    assign res_last = s2_pick[3] && s2_chlast_reg;

    // ---------------- stage 3: products ----------------
    logic               s3_v_reg, s3_last_reg;
    logic signed [37:0] s3_prod_reg [9];
    logic [15:0]        s3_row_reg;
    logic [10:0]        s3_col_reg;
    logic [1:0]         s3_ch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_v_reg <= 1'b0;
        end else if (en) begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                s3_prod_reg[k] <= 38'(c3f_pkg::kern_coef(mode_reg, 4'(k)) *
                                      $signed({1'b0, tap[k]}));
            end
            s3_row_reg  <= res_row;
            s3_col_reg  <= res_col[10:0];
            s3_ch_reg   <= s2_ch_reg;
            s3_last_reg <= res_last;
        end
    end

    // ---------------- stage 4: row sums ----------------
    logic               s4_v_reg, s4_last_reg;
    logic signed [39:0] s4_sum_reg [3];
    logic [15:0]        s4_row_reg;
    logic [10:0]        s4_col_reg;
    logic [1:0]         s4_ch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_v_reg <= 1'b0;
        end else if (en) begin
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int ky = 0; ky < 3; ky++) begin
                s4_sum_reg[ky] <= 40'(s3_prod_reg[ky*3]) + 40'(s3_prod_reg[ky*3+1]) +
                                  40'(s3_prod_reg[ky*3+2]);
            end
            s4_row_reg  <= s3_row_reg;
            s4_col_reg  <= s3_col_reg;
            s4_ch_reg   <= s3_ch_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    // ---------------- stage 5: total, round, offset, output register ----------------
    logic signed [39:0] total;
    logic [20:0]        filt;
    logic               out_v_reg, out_last_reg;
    logic [49:0]        out_data_reg;

    assign total = s4_sum_reg[0] + s4_sum_reg[1] + s4_sum_reg[2] + 40'sd32768;
    assign filt  = total[36:16] + c3f_pkg::mode_offset(mode_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {s4_ch_reg, s4_col_reg, s4_row_reg, filt};
            out_last_reg <= s4_last_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'd0, out_data_reg};
    assign m_tlast  = out_last_reg;

    // ---------------- checks ----------------
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_v_reg && !en |-> !s_tready)
        else $error("input taken while stage 1 is stalled");

    a_expand_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_v_reg |-> s2_mask_reg != 4'd0)
        else $error("expansion stage valid with no result left");

    a_fwd_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_v_reg |-> s1_v_reg)
        else $error("line store forward without an item in stage 1");

    a_expand_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_v_reg && !s2_last && s1_v_reg |-> !s1_leave)
        else $error("stage 1 advanced over pending results");

endmodule

// ----- sim/conv3x3_image_filter_tb.sv -----
`timescale 1ns / 100ps
// Testbench for the 3x3 image filter: drives sample and register traffic under random flow
// control and checks every result against an independent predictor. Depends on c3f_pkg.

typedef struct packed {
    logic signed [20:0] filtered;
    logic [15:0]        row;
    logic [10:0]        col;
    logic [1:0]         chan;
    logic               last;
} filt_result_t;

class filt_scoreboard;
    logic [2:0]  mode_r;
    logic [11:0] width_r;
    logic [15:0] height_r;
    logic [2:0]  chans_r;
    logic [15:0] line1 [8192];
    logic [15:0] line2 [8192];
    logic [15:0] win [4][3][3];
    int unsigned row_pos, col_pos, chan_pos;
    filt_result_t pending[$];
    int errors;

    function new();
        mode_r = c3f_pkg::MODE_IDENTITY;
        width_r = 1;
        height_r = 1;
        chans_r = 1;
        row_pos = 0;
        col_pos = 0;
        chan_pos = 0;
        errors = 0;
    endfunction

    function void write_reg(c3f_pkg::cfg_index_t idx, logic [15:0] val);
        case (idx)
            c3f_pkg::CFG_FILTER_MODE:   mode_r = val[2:0];
            c3f_pkg::CFG_IMAGE_WIDTH:   width_r = val[11:0];
            c3f_pkg::CFG_IMAGE_HEIGHT:  height_r = val;
            c3f_pkg::CFG_CHANNEL_COUNT: chans_r = val[2:0];
            default: ;
        endcase
        if (idx != c3f_pkg::CFG_FILTER_MODE) begin
            row_pos = 0;
            col_pos = 0;
            chan_pos = 0;
        end
    endfunction

    function int unsigned clamp_slot(int t, int lim, int cur);
        int s;
        if (t < 0) t = 0;
        if (t > lim - 1) t = lim - 1;
        s = t - cur + 2;
        if (s < 0) s = 0;
        if (s > 2) s = 2;
        return s;
    endfunction

    function logic signed [20:0] tap_weight(int m, int k);
        int ws [7][9] = '{
            '{4681, 7802, 4681, 7802, 15604, 7802, 4681, 7802, 4681},
            '{-4096, -4096, -4096, -4096, 32768, -4096, -4096, -4096, -4096},
            '{10923, 0, -10923, 10923, 0, -10923, 10923, 0, -10923},
            '{10923, 10923, 10923, 0, 0, 0, -10923, -10923, -10923},
            '{-65536, -131072, -65536, -131072, 851968, -131072, -65536, -131072,
              -65536},
            '{7282, 7282, 7282, 7282, 7282, 7282, 7282, 7282, 7282},
            '{0, 0, 0, 0, 65536, 0, 0, 0, 0}};
        return 21'(ws[m][k]);
    endfunction

    // Window sum over one pixel, rounded from Q16 and offset
    function logic [20:0] filter_at(int ch, int r, int c, int rr, int cc, int h, int w,
                                    int m);
        longint acc;
        longint res;
        int rs, cs;
        acc = 0;
        for (int ky = 0; ky < 3; ky++) begin
            rs = clamp_slot(r - 1 + ky, h, rr);
            for (int kx = 0; kx < 3; kx++) begin
                cs = clamp_slot(c - 1 + kx, w, cc);
                acc += longint'(tap_weight(m, ky * 3 + kx)) * longint'(win[ch][cs][rs]);
            end
        end
        res = (acc + 32768) >>> 16;
        if (m == c3f_pkg::MODE_LAPLACIAN || m == c3f_pkg::MODE_HGRAD ||
            m == c3f_pkg::MODE_VGRAD) res += 32768;
        return res[20:0];
    endfunction

    // Advance the raster position and queue the results this sample completes
    function void note_sample(logic [15:0] x);
        int w, h, nc, m, rr, cc, ch, idx;
        int rows[$], cols[$];
        logic [15:0] p1, p2;
        filt_result_t e;
        w = (width_r == 0) ? 1 : (width_r > 2048) ? 2048 : width_r;
        h = (height_r == 0) ? 1 : height_r;
        nc = (chans_r == 0) ? 1 : (chans_r > 4) ? 4 : chans_r;
        m = (mode_r > c3f_pkg::MODE_IDENTITY) ? c3f_pkg::MODE_IDENTITY : mode_r;
        rr = (row_pos >= h) ? h - 1 : row_pos;
        cc = (col_pos >= w) ? w - 1 : col_pos;
        ch = (chan_pos >= nc) ? nc - 1 : chan_pos;
        idx = cc * 4 + ch;
        p1 = line1[idx];
        p2 = line2[idx];
        line2[idx] = p1;
        line1[idx] = x;
        for (int k = 0; k < 3; k++) begin
            win[ch][0][k] = win[ch][1][k];
            win[ch][1][k] = win[ch][2][k];
        end
        win[ch][2][0] = p2;
        win[ch][2][1] = p1;
        win[ch][2][2] = x;
        if (rr >= 1) rows.push_back(rr - 1);
        if (rr == h - 1) rows.push_back(rr);
        if (cc >= 1) cols.push_back(cc - 1);
        if (cc == w - 1) cols.push_back(cc);
        foreach (rows[i]) foreach (cols[j]) begin
            e.filtered = filter_at(ch, rows[i], cols[j], rr, cc, h, w, m);
            e.row = 16'(rows[i]);
            e.col = 11'(cols[j]);
            e.chan = 2'(ch);
            e.last = (rows[i] == h - 1) && (cols[j] == w - 1) && (ch == nc - 1);
            pending.push_back(e);
        end
        ch++;
        if (ch >= nc) begin
            ch = 0;
            cc++;
            if (cc >= w) begin
                cc = 0;
                rr++;
                if (rr >= h) rr = 0;
            end
        end
        chan_pos = ch;
        col_pos = cc;
        row_pos = rr;
    endfunction

    function void check_result(filt_result_t got);
        filt_result_t e;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
        end
        e = pending.pop_front();
        if (got !== e) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", e, got);
        end
    endfunction
endclass

module conv3x3_image_filter_tb;
    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tlast;

    filt_scoreboard filt_sb;
    int send_idle_pct;
    int recv_stall_pct;

    conv3x3_image_filter u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Apply receiver backpressure at the falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            filt_sb.check_result({m_tdata[20:0], m_tdata[36:21], m_tdata[47:37],
                                  m_tdata[49:48], m_tlast});
    end

    task automatic write_reg(c3f_pkg::cfg_index_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        filt_sb.write_reg(idx, val);
    endtask

    // Offer one request, holding it until accepted; valid stays up for the next one
    task automatic send_sample(logic [15:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        do @(posedge aclk); while (!s_tready);
        filt_sb.note_sample(x);
        @(negedge aclk);
    endtask

    // Drop the input, wait until every expected result is back, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (filt_sb.pending.size() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic set_frame(int m, int w, int h, int c);
        write_reg(c3f_pkg::CFG_FILTER_MODE, 16'(m));
        write_reg(c3f_pkg::CFG_IMAGE_WIDTH, 16'(w));
        write_reg(c3f_pkg::CFG_IMAGE_HEIGHT, 16'(h));
        write_reg(c3f_pkg::CFG_CHANNEL_COUNT, 16'(c));
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic send_frame(int w, int h, int c, bit extreme);
        for (int i = 0; i < w * h * c; i++)
            send_sample(extreme ? ((i % 2) ? 16'hFFFF : 16'h0000) : rand_sample());
    endtask

    initial begin
        int m, w, h, c;
        filt_sb = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = c3f_pkg::CFG_FILTER_MODE;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset geometry: one pixel, identity, extremes
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        drain();

        // Every mode on a checkerboard of extremes, including the undefined mode
        for (int md = c3f_pkg::MODE_LOWPASS; md <= 7; md++) begin
            set_frame(md, 3, 3, 1);
            send_frame(3, 3, 1, 1);
            drain();
        end
        // Zero-sized registers act as one; oversize width and channel count clamp
        set_frame(c3f_pkg::MODE_HIGHPASS, 0, 0, 0);
        send_sample(16'h8000);
        drain();
        set_frame(c3f_pkg::MODE_LAPLACIAN, 2, 2, 7);
        send_frame(2, 2, 4, 1);
        drain();
        set_frame(c3f_pkg::MODE_BOXCAR, 4095, 1, 1);
        send_frame(2, 1, 1, 0);
        drain();
        // A single tall column with two channels
        set_frame(c3f_pkg::MODE_VGRAD, 1, 4, 2);
        send_frame(1, 4, 2, 0);
        drain();

        // Random frames under four flow-control phases
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 25 : 52) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 25 : 52) : 0;
            for (int f = 0; f < 2; f++) begin
                m = $urandom_range(7);
                w = $urandom_range(1, 5);
                h = $urandom_range(1, 4);
                c = $urandom_range(1, 4);
                if (w * h * c > 30) c = 1;
                set_frame(m, w, h, c);
                send_frame(w, h, c, 0);
                drain();
                // Change the mode alone between frames
                write_reg(c3f_pkg::CFG_FILTER_MODE, 16'($urandom_range(7)));
            end
        end

        // Wider row, then part of the next row of the frame
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_frame(c3f_pkg::MODE_LOWPASS, 8, 2, 1);
        send_frame(8, 1, 1, 0);
        send_frame(3, 1, 1, 0);
        drain();

        if (filt_sb.errors == 0 && filt_sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end
endmodule

// ----- conv3x3_image_filter.f -----
hdl/c3f_pkg.sv
hdl/conv3x3_image_filter.sv
sim/conv3x3_image_filter_tb.sv
